// ===== design/fpme_pkg.sv =====
// Shared widths, register codes, reset values and controller/datapath interface types.
`default_nettype none

package fpme_pkg;

	localparam int STAMP_W   = 48;
	localparam int PERIOD_W  = 17;
	localparam int CFG_IDX_W = 2;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_FLOOR   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_CEILING = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_PERIOD = 2'd2;

	// register values after reset
	localparam logic [PERIOD_W-1:0] RST_PERIOD_FLOOR   = 17'd4167;
	localparam logic [PERIOD_W-1:0] RST_PERIOD_CEILING = 17'd100000;
	localparam logic [PERIOD_W-1:0] RST_DEFAULT_PERIOD = 17'd16667;

	// controller to datapath
	typedef struct packed {
		logic capture;   // latch the incoming timestamp
		logic delta;     // form the period, move timestamp to previous
		logic store;     // clamp and write the ring, step slot and fill count
		logic scan_init; // reset the scan and preload the default period
		logic rd_issue;  // read the next ring entry
		logic load_out;  // move the scan result to the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic have_prev;  // a timestamp has already been seen
		logic issue_left; // ring entries still to be read
		logic rd_pend;    // a read is in flight
	} status_t;

endpackage

`default_nettype wire

// ===== design/frame_period_min_estimator_top.sv =====
// Top level of the frame period minimum estimator: controller plus datapath.
`default_nettype none

// Channel   Direction  Handshake             Word
// in        sink       in_valid / in_ready   now_us, 48-bit timestamp in us
// out       source     out_valid / out_ready estimate_us, 17-bit period in us
// cfg       sink       cfg_wr_en             cfg_index, cfg_data (17 bits)
//
// One input word at a time: from acceptance the word passes through delta, store and
// a scan of fill_count ring entries, fill_count taken after this word's store (16 with
// a full ring), before the result is loaded; the arming word stores nothing. The scan
// reads one entry per cycle through the ring's single registered read port, then waits
// for the last read to return. in_ready is back in the cycle after the load.
// A result waiting in the output register does not hold off the next input word;
// only its own load waits for out_ready.
// Reset is asynchronous; the ring needs no clearing pass, as the scan only visits
// entries already written.

module frame_period_min_estimator_top #(
	parameter int HISTORY_DEPTH = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [fpme_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [fpme_pkg::PERIOD_W-1:0]     cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [fpme_pkg::STAMP_W-1:0]      now_us,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic      [fpme_pkg::PERIOD_W-1:0]     estimate_us
);

	fpme_pkg::cmd_t    cmd;
	fpme_pkg::status_t status;

	// sequencing: idle -> delta -> (store) -> scan -> done
	fpme_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// period clamp, ring, running minimum and output word register
	fpme_dpath #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.now_us      (now_us),
		.estimate_us (estimate_us),
		.cmd         (cmd),
		.status      (status)
	);

endmodule

`default_nettype wire

// ===== design/fpme_ctrl.sv =====
// Controller state machine: sequences capture, period store, ring scan and output load.
`default_nettype none

module fpme_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire fpme_pkg::status_t status,
	output fpme_pkg::cmd_t         cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DELTA,
		ST_STORE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.capture = in_valid;
			end
			ST_DELTA: begin
				cmd.delta     = 1'b1;
				cmd.scan_init = 1'b1;
			end
			ST_STORE: begin
				cmd.store     = 1'b1;
				cmd.scan_init = 1'b1;
			end
			ST_SCAN: begin
				cmd.rd_issue = status.issue_left;
			end
			ST_DONE: begin
				cmd.load_out = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// a fresh load sets valid, otherwise it holds until taken
			out_valid_q <= ((state_q == ST_DONE) && out_free) || (out_valid_q && !out_ready);
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DELTA;
					end
				end
				ST_DELTA: begin
					// first timestamp only arms: nothing to store
					state_q <= status.have_prev ? ST_STORE : ST_SCAN;
				end
				ST_STORE: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (!status.issue_left && !status.rd_pend) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/fpme_dpath.sv =====
// Datapath: config registers, period clamp, ring memory, minimum scan and output register.
`default_nettype none

module fpme_dpath #(
	parameter int HISTORY_DEPTH = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wr_en,
	input  wire logic [fpme_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [fpme_pkg::PERIOD_W-1:0]       cfg_data,
	input  wire logic [fpme_pkg::STAMP_W-1:0]        now_us,
	output logic      [fpme_pkg::PERIOD_W-1:0]       estimate_us,
	input  wire fpme_pkg::cmd_t                      cmd,
	output fpme_pkg::status_t                        status
);

	localparam int IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CW = $clog2(HISTORY_DEPTH + 1);

	logic [fpme_pkg::PERIOD_W-1:0] floor_q;
	logic [fpme_pkg::PERIOD_W-1:0] ceiling_q;
	logic [fpme_pkg::PERIOD_W-1:0] default_q;

	logic [fpme_pkg::STAMP_W-1:0]  now_q;
	logic [fpme_pkg::STAMP_W-1:0]  prev_q;
	logic                          have_prev_q;
	logic [fpme_pkg::STAMP_W-1:0]  delta_q;

	logic [IW-1:0]                 slot_q;
	logic [CW-1:0]                 fill_q;

	logic [fpme_pkg::PERIOD_W-1:0] ring [HISTORY_DEPTH];
	logic [CW-1:0]                 rd_idx_q;
	logic [fpme_pkg::PERIOD_W-1:0] rd_data_s1;
	logic                          rd_pend_s1;

	logic [fpme_pkg::PERIOD_W-1:0] best_q;
	logic                          first_q;
	logic [fpme_pkg::PERIOD_W-1:0] est_q;

	logic [fpme_pkg::STAMP_W-1:0]  lo_clamped;
	logic [fpme_pkg::STAMP_W-1:0]  clamped;

	// floor first, then ceiling: ceiling wins when they cross
	always_comb begin
		lo_clamped = (delta_q < {31'd0, floor_q}) ? {31'd0, floor_q} : delta_q;
		clamped    = (lo_clamped > {31'd0, ceiling_q}) ? {31'd0, ceiling_q} : lo_clamped;
	end

	assign status.have_prev  = have_prev_q;
	assign status.issue_left = (rd_idx_q < fill_q);
	assign status.rd_pend    = rd_pend_s1;
	assign estimate_us       = est_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q   <= fpme_pkg::RST_PERIOD_FLOOR;
			ceiling_q <= fpme_pkg::RST_PERIOD_CEILING;
			default_q <= fpme_pkg::RST_DEFAULT_PERIOD;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				fpme_pkg::CFG_PERIOD_FLOOR:   floor_q   <= cfg_data;
				fpme_pkg::CFG_PERIOD_CEILING: ceiling_q <= cfg_data;
				fpme_pkg::CFG_DEFAULT_PERIOD: default_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			slot_q      <= '0;
			fill_q      <= '0;
			rd_idx_q    <= '0;
			rd_pend_s1  <= 1'b0;
			first_q     <= 1'b0;
		end else begin
			if (cmd.delta) begin
				prev_q      <= now_q;
				have_prev_q <= 1'b1;
			end
			if (cmd.store) begin
				slot_q <= (slot_q == IW'(HISTORY_DEPTH - 1)) ? '0 : slot_q + 1'b1;
				if (fill_q != CW'(HISTORY_DEPTH)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			rd_pend_s1 <= cmd.rd_issue;
			if (cmd.scan_init) begin
				rd_idx_q <= '0;
				first_q  <= 1'b1;
			end else begin
				if (cmd.rd_issue) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
				if (rd_pend_s1) begin
					first_q <= 1'b0;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			now_q <= now_us;
		end
		if (cmd.delta) begin
			delta_q <= (now_q >= prev_q) ? (now_q - prev_q) : '0;
		end
		if (cmd.scan_init) begin
			best_q <= default_q;
		end else if (rd_pend_s1 && (first_q || rd_data_s1 < best_q)) begin
			best_q <= rd_data_s1;
		end
		if (cmd.load_out) begin
			est_q <= best_q;
		end
	end

	// ring memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			ring[slot_q] <= clamped[fpme_pkg::PERIOD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_issue) begin
			rd_data_s1 <= ring[rd_idx_q[IW-1:0]];
		end
	end

endmodule

`default_nettype wire

// ===== design/fpme_checker.sv =====
// Port-level assertions for the estimator, bound to the top level.
`default_nettype none

module fpme_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [fpme_pkg::PERIOD_W-1:0] estimate_us
);

	// one word in flight: busy straight after an acceptance
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while previous word still in work");

	// a new result comes out as the block returns to idle
	a_result_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result presented while block still busy");

	// no result can be ready in the cycle after an acceptance
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result appeared too soon after acceptance");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(estimate_us))
		else $error("stalled result word changed or dropped");

endmodule

bind frame_period_min_estimator_top fpme_checker u_fpme_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.estimate_us (estimate_us)
);

`default_nettype wire

// ===== test/frame_period_min_estimator_top_tb.sv =====
// Self-checking testbench for the frame period minimum estimator: timestamp words in, estimates out.
`timescale 1ns / 1ps

module frame_period_min_estimator_top_tb;
	import fpme_pkg::*;

	localparam int CLK_PERIOD   = 12;
	localparam int HIST_DEPTH   = 16;
	localparam int LONG_HOLD    = 300;  // cycles the receiver refuses words in the stall test
	localparam int DRAIN_CYCLES = 40;   // well past the scan of a full ring
	localparam int REPORT_LIMIT = 10;

	// index 3 decodes to no register; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;
	localparam logic [STAMP_W-1:0]   STAMP_MAX       = {STAMP_W{1'b1}};
	localparam logic [PERIOD_W-1:0]  PERIOD_MAX      = {PERIOD_W{1'b1}};

	typedef enum int {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_PATTERN} rx_mode_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [PERIOD_W-1:0]   cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [STAMP_W-1:0]    now_us;
	logic                  out_valid;
	logic                  out_ready;
	logic [PERIOD_W-1:0]   estimate_us;

	// Predictor copy of the registers and the period history
	logic [PERIOD_W-1:0]   floor_reg;
	logic [PERIOD_W-1:0]   ceiling_reg;
	logic [PERIOD_W-1:0]   default_reg;
	logic [PERIOD_W-1:0]   hist_period [HIST_DEPTH];
	int                    hist_slot;
	int                    hist_fill;
	logic [STAMP_W-1:0]    last_stamp;
	logic                  stamp_seen;

	// Estimates owed by the block, oldest first
	logic [PERIOD_W-1:0]   pending_estimates [$];
	int                    mismatches;

	logic [STAMP_W-1:0]    sent_stamp;    // last timestamp offered; random stamps walk from it
	rx_mode_t              rx_mode;
	logic                  hold_request;  // asks the receiver for one long hold-off

	frame_period_min_estimator_top #(
		.HISTORY_DEPTH(HIST_DEPTH)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.now_us     (now_us),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.estimate_us(estimate_us)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Hard stop in case the block hangs on a handshake
	initial begin
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// Steps the predictor by one timestamp and returns the estimate it owes.
	// The first timestamp only arms; later ones store a clamped gap, floor
	// first and ceiling second, so the ceiling wins when they cross.
	function automatic logic [PERIOD_W-1:0] predict_estimate(input logic [STAMP_W-1:0] stamp);
		logic [STAMP_W-1:0]  gap;
		logic [PERIOD_W-1:0] lowest;
		int                  i;
		if (stamp_seen) begin
			// time running backwards counts as a zero gap
			gap = (stamp >= last_stamp) ? stamp - last_stamp : '0;
			if (gap < floor_reg)
				gap = STAMP_W'(floor_reg);
			if (gap > ceiling_reg)
				gap = STAMP_W'(ceiling_reg);
			hist_period[hist_slot] = gap[PERIOD_W-1:0];
			hist_slot = (hist_slot + 1) % HIST_DEPTH;
			if (hist_fill < HIST_DEPTH)
				hist_fill++;
		end
		last_stamp = stamp;
		stamp_seen = 1'b1;
		if (hist_fill == 0)
			return default_reg;
		lowest = hist_period[0];
		for (i = 1; i < hist_fill; i++)
			if (hist_period[i] < lowest)
				lowest = hist_period[i];
		return lowest;
	endfunction

	// Random timestamp: mostly forward steps around the clamp window, with tiny steps,
	// wide jumps, backward steps, fully random words and words near the top mixed in.
	function automatic logic [STAMP_W-1:0] next_stamp();
		int unsigned lo;
		int unsigned hi;
		int unsigned pick;
		logic [63:0] wide;
		lo = 32'((floor_reg < ceiling_reg) ? floor_reg : ceiling_reg);
		hi = 32'((floor_reg < ceiling_reg) ? ceiling_reg : floor_reg);
		lo = (lo > 1500) ? lo - 1500 : 0;
		hi = hi + 1500;
		pick = $urandom_range(0, 99);
		wide = {$urandom, $urandom};
		if (pick < 55)
			return sent_stamp + $urandom_range(lo, hi);
		else if (pick < 68)
			return sent_stamp + $urandom_range(0, 3);
		else if (pick < 76)
			return sent_stamp + $urandom;
		else if (pick < 85)
			return sent_stamp - $urandom_range(1, 2000);
		else if (pick < 93)
			return wide[STAMP_W-1:0];
		else
			return STAMP_MAX - $urandom_range(0, 200000);
	endfunction

	task automatic flag_mismatch(input string what, input int want, input int got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("%t estimate_us %s: expected %0d actual %0d", $time, what, want, got);
	endtask

	// Offers one timestamp word and returns at the edge that takes it. Valid
	// is left high so a following word goes out back to back.
	task automatic send_stamp(input logic [STAMP_W-1:0] stamp);
		logic [PERIOD_W-1:0] owed;
		in_valid   <= 1'b1;
		now_us     <= stamp;
		sent_stamp  = stamp;
		do
			@(posedge clk);
		while (!in_ready);
		owed = predict_estimate(stamp);
		pending_estimates.insert(pending_estimates.size(), owed);
	endtask

	task automatic pause_sender(input int cycles);
		if (cycles > 0) begin
			in_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Register write, only once every owed estimate has come out so the
	// block is idle. Every word yields a result, so an empty queue suffices.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PERIOD_W-1:0] value);
		in_valid <= 1'b0;
		while (pending_estimates.size() != 0)
			@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			CFG_PERIOD_FLOOR:   floor_reg   = value;
			CFG_PERIOD_CEILING: ceiling_reg = value;
			CFG_DEFAULT_PERIOD: default_reg = value;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// The default is only visible before the first period lands, so it is
	// set here, ahead of the arming word. A write to the spare index follows
	// and must leave it alone.
	task automatic test_arming();
		write_reg(CFG_DEFAULT_PERIOD, PERIOD_MAX);
		write_reg(CFG_SPARE_INDEX, 17'd7);
		send_stamp('0);            // zero is a real stamp: arms, reports the default
		send_stamp('0);            // zero gap, lifted to the reset floor
		send_stamp(48'd20000);
		pause_sender(3);
	endtask

	// Gaps either side of the reset floor, at and just above the reset ceiling, time going
	// backwards, huge jumps and the top of the timestamp range.
	task automatic test_clamp_limits();
		send_stamp(sent_stamp + RST_PERIOD_FLOOR - 1);
		send_stamp(sent_stamp + RST_PERIOD_FLOOR + 1);
		send_stamp(sent_stamp + RST_PERIOD_CEILING);
		send_stamp(sent_stamp + RST_PERIOD_CEILING + 1);
		send_stamp(sent_stamp - 5);
		send_stamp(sent_stamp + (48'd1 << 47));
		send_stamp(STAMP_MAX);
		send_stamp('0);            // wraps back below the previous stamp
		pause_sender(2);
	endtask

	// Zero floor, zero default, floor above ceiling, floor equal to ceiling.
	task automatic test_register_extremes();
		write_reg(CFG_PERIOD_FLOOR, '0);
		write_reg(CFG_PERIOD_CEILING, PERIOD_MAX);
		write_reg(CFG_DEFAULT_PERIOD, '0);
		send_stamp(sent_stamp);    // a zero period may now be stored
		send_stamp(sent_stamp + PERIOD_MAX + 5);
		write_reg(CFG_PERIOD_FLOOR, PERIOD_MAX);
		write_reg(CFG_PERIOD_CEILING, 17'd1);
		send_stamp(sent_stamp + 3);
		write_reg(CFG_PERIOD_CEILING, PERIOD_MAX);
		send_stamp(sent_stamp + 1);
		send_stamp(sent_stamp + 48'd500000);
		pause_sender(2);
	endtask

	// Receiver holds off for a long stretch while words keep coming: one
	// estimate parks in the output register, the next finishes its scan and
	// waits to load, and the input must then stall.
	task automatic test_output_stall();
		int n;
		rx_mode      = RX_ALWAYS;
		hold_request = 1'b1;
		for (n = 0; n < 8; n++)
			send_stamp(sent_stamp + $urandom_range(1000, 50000));
		pause_sender(1);
	endtask

	// One setting of the registers, then random words in bursts with random
	// gaps, long ones now and then so pauses land on every scan length.
	task automatic test_random_stamps(input int count, input logic [PERIOD_W-1:0] lo_reg,
			input logic [PERIOD_W-1:0] hi_reg, input logic [PERIOD_W-1:0] dflt,
			input rx_mode_t mode);
		int sent;
		int burst;
		int gap;
		write_reg(CFG_PERIOD_FLOOR, lo_reg);
		write_reg(CFG_PERIOD_CEILING, hi_reg);
		write_reg(CFG_DEFAULT_PERIOD, dflt);
		rx_mode = mode;
		sent    = 0;
		while (sent < count) begin
			burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
			repeat (burst) begin
				send_stamp(next_stamp());
				sent++;
			end
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 5);
			pause_sender(gap);
		end
	endtask

	// Receiver: its own ready pattern per mode, plus the long hold-off on
	// request, counted here so the sender is free to keep offering words.
	initial begin : receiver
		int hold_left;
		int rx_tick;
		hold_left = 0;
		rx_tick   = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			rx_tick++;
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_ALWAYS:  out_ready <= 1'b1;
					RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
					RX_MOSTLY:  out_ready <= ($urandom_range(0, 9) < 8);
					RX_PATTERN: out_ready <= ((rx_tick % 7) > 2);
					default:    out_ready <= 1'b1;
				endcase
			end
		end
	end

	// Checker: every estimate taken is matched against the oldest one owed
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_estimates.size() == 0) begin
				flag_mismatch("unexpected word", -1, estimate_us);
			end else begin
				if (estimate_us !== pending_estimates[0])
					flag_mismatch("wrong value", pending_estimates[0], estimate_us);
				void'(pending_estimates.pop_front());
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		now_us       = '0;
		rx_mode      = RX_ALWAYS;
		hold_request = 1'b0;
		mismatches   = 0;
		sent_stamp   = '0;

		// predictor starts from the reset state
		floor_reg   = RST_PERIOD_FLOOR;
		ceiling_reg = RST_PERIOD_CEILING;
		default_reg = RST_DEFAULT_PERIOD;
		foreach (hist_period[i])
			hist_period[i] = '0;
		hist_slot  = 0;
		hist_fill  = 0;
		last_stamp = '0;
		stamp_seen = 1'b0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_arming();
		test_clamp_limits();
		test_register_extremes();
		test_output_stall();
		test_random_stamps(250, RST_PERIOD_FLOOR, RST_PERIOD_CEILING, RST_DEFAULT_PERIOD,
				RX_ALWAYS);
		test_random_stamps(250, '0, PERIOD_MAX, PERIOD_MAX, RX_COIN);
		test_random_stamps(100, 17'd1, 17'd1, '0, RX_MOSTLY);
		test_random_stamps(100, 17'd90000, 17'd20000, 17'd1, RX_PATTERN);
		test_random_stamps(350, PERIOD_W'($urandom_range(1, PERIOD_MAX)),
				PERIOD_W'($urandom_range(1, PERIOD_MAX)),
				PERIOD_W'($urandom_range(0, PERIOD_MAX)), RX_COIN);
		test_random_stamps(350, 17'd300, 17'd6000, 17'd16667, RX_MOSTLY);

		// drain, then let the block sit a while to catch stray words
		pause_sender(1);
		while (pending_estimates.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending_estimates.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
